// ----- hw/rtl/pctdec_pkg.sv -----
// Shared types, constants and hex helpers for the percent decoder.
`default_nettype none
package pctdec_pkg;

	localparam logic [7:0] PCT_CHAR  = 8'h25;
	localparam logic [7:0] NIB_MASK  = 8'h0f;
	localparam logic [7:0] HI_MASK   = 8'hf0;
	localparam int         Q_DEPTH   = 4;
	localparam int         Q_PTR_W   = 2;
	localparam int         Q_CNT_W   = 3;
	localparam int         MAX_BURST = 3;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       is_last;
	} in_req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       string_done;
		logic       overflow;
	} out_req_t;

	// One decoded item's worth of output, 1 to 3 bytes.
	typedef struct packed {
		logic [MAX_BURST-1:0][7:0] bytes;
		logic [1:0]                n;
		logic                      done;
		logic                      ovf;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic hex_ok(input logic [7:0] c);
		logic r;
		r = ((c >= 8'h30) && (c <= 8'h39)) ||
		    ((c >= 8'h61) && (c <= 8'h66)) ||
		    ((c >= 8'h41) && (c <= 8'h46));
		return r;
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] v;
		v = 8'h00;
		if ((c >= 8'h30) && (c <= 8'h39)) begin
			v = c - 8'h30;
		end else if ((c >= 8'h61) && (c <= 8'h66)) begin
			v = c - 8'h57;
		end else if ((c >= 8'h41) && (c <= 8'h46)) begin
			v = c - 8'h37;
		end
		return v[3:0];
	endfunction

	function automatic logic [7:0] hex_pair(input logic [7:0] hi, input logic [7:0] lo);
		logic [7:0] r;
		r = (({4'h0, hex_val(hi)} << 4) & HI_MASK) | ({4'h0, hex_val(lo)} & NIB_MASK);
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/pctdec_front.sv -----
// Front end: escape parsing, output limit accounting, queue entry build.
`default_nettype none
module pctdec_front #(
	parameter int COUNT_WIDTH = 16
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     accept,
	input  pctdec_pkg::in_req_t     req,
	input  wire [15:0]              limit,
	output logic                    push,
	output pctdec_pkg::entry_t      entry
);

	localparam int CMPW = ((COUNT_WIDTH > 16) ? COUNT_WIDTH : 16) + 2;

	logic [1:0]             pend_q;
	logic [7:0]             held_q;
	logic [COUNT_WIDTH-1:0] cnt_q;
	logic                   ovf_q;

	logic [1:0]             pend_n;
	logic [7:0]             held_n;
	logic [2:0][7:0]        cand;
	logic [1:0]             nc;
	logic [2:0]             ok;
	logic [1:0]             nout;
	logic                   ovf_n;
	logic [CMPW-1:0]        cnt_ext;
	logic [CMPW-1:0]        lim_ext;
	logic [CMPW-1:0]        cmax_ext;
	logic [7:0]             b;

	assign b        = req.in_byte;
	assign cnt_ext  = CMPW'(cnt_q);
	assign lim_ext  = CMPW'(limit);
	assign cmax_ext = CMPW'((64'd1 << COUNT_WIDTH) - 64'd1);

	always_comb begin
		pend_n = pend_q;
		held_n = held_q;
		cand   = '0;
		nc     = 2'd0;
		case (pend_q)
			2'd1: begin
				if (pctdec_pkg::hex_ok(b)) begin
					held_n = b;
					pend_n = 2'd2;
				end else begin
					cand[0] = pctdec_pkg::PCT_CHAR;
					nc      = 2'd1;
					if (b == pctdec_pkg::PCT_CHAR) begin
						pend_n = 2'd1;
					end else begin
						cand[1] = b;
						nc      = 2'd2;
						pend_n  = 2'd0;
					end
				end
			end
			2'd2: begin
				if (pctdec_pkg::hex_ok(b)) begin
					cand[0] = pctdec_pkg::hex_pair(held_q, b);
					nc      = 2'd1;
					pend_n  = 2'd0;
				end else begin
					cand[0] = pctdec_pkg::PCT_CHAR;
					cand[1] = held_q;
					nc      = 2'd2;
					if (b == pctdec_pkg::PCT_CHAR) begin
						pend_n = 2'd1;
					end else begin
						cand[2] = b;
						nc      = 2'd3;
						pend_n  = 2'd0;
					end
				end
			end
			default: begin
				if (b == pctdec_pkg::PCT_CHAR) begin
					pend_n = 2'd1;
				end else begin
					cand[0] = b;
					nc      = 2'd1;
					pend_n  = 2'd0;
				end
			end
		endcase

		// flush a cut-short escape at end of URI
		if (req.is_last) begin
			if (pend_n == 2'd1) begin
				case (nc)
					2'd0:    cand[0] = pctdec_pkg::PCT_CHAR;
					2'd1:    cand[1] = pctdec_pkg::PCT_CHAR;
					default: cand[2] = pctdec_pkg::PCT_CHAR;
				endcase
				nc = nc + 2'd1;
			end else if (pend_n == 2'd2) begin
				cand[0] = pctdec_pkg::PCT_CHAR;
				cand[1] = held_n;
				nc      = 2'd2;
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			ok[k] = !ovf_q && ((cnt_ext + CMPW'(k)) < lim_ext) &&
			        ((cnt_ext + CMPW'(k)) < cmax_ext);
		end
		nout = 2'(((nc > 2'd0) && ok[0]) ? 1 : 0) +
		       2'(((nc > 2'd1) && ok[1]) ? 1 : 0) +
		       2'(((nc > 2'd2) && ok[2]) ? 1 : 0);
		ovf_n = ovf_q || (nc > nout);
		if (req.is_last && ovf_n) begin
			entry.bytes = '0;
			entry.n     = 2'd1;
			entry.done  = 1'b1;
			entry.ovf   = 1'b1;
		end else begin
			entry.bytes = cand;
			entry.n     = nout;
			entry.done  = req.is_last;
			entry.ovf   = 1'b0;
		end
		push = accept && (entry.n != 2'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
			held_q <= 8'h00;
			cnt_q  <= '0;
			ovf_q  <= 1'b0;
		end else if (accept) begin
			if (req.is_last) begin
				pend_q <= 2'd0;
				held_q <= 8'h00;
				cnt_q  <= '0;
				ovf_q  <= 1'b0;
			end else begin
				pend_q <= pend_n;
				held_q <= held_n;
				cnt_q  <= cnt_q + COUNT_WIDTH'(nout);
				ovf_q  <= ovf_n;
			end
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/pctdec_queue.sv -----
// Short entry queue between the parser and the byte serializer.
`default_nettype none
module pctdec_queue (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    push,
	input  pctdec_pkg::entry_t     wr_entry,
	input  wire                    pop,
	output pctdec_pkg::entry_t     rd_entry,
	output pctdec_pkg::q_stat_t    stat
);

	pctdec_pkg::entry_t                   mem_q [pctdec_pkg::Q_DEPTH];
	logic [pctdec_pkg::Q_PTR_W-1:0]       wr_q;
	logic [pctdec_pkg::Q_PTR_W-1:0]       rd_q;
	logic [pctdec_pkg::Q_CNT_W-1:0]       cnt_q;

	assign stat.full  = (cnt_q == pctdec_pkg::Q_CNT_W'(pctdec_pkg::Q_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign rd_entry   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full)
		else $error("queue push while full");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("queue pop while empty");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= pctdec_pkg::Q_CNT_W'(pctdec_pkg::Q_DEPTH))
		else $error("queue count out of range");
	a_entry_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (wr_entry.n != 2'd0))
		else $error("empty entry pushed");

endmodule
`default_nettype wire

// ----- hw/rtl/pctdec_back.sv -----
// Back end: walks queue entries byte by byte into the output register.
`default_nettype none
module pctdec_back (
	input  wire                    clk,
	input  wire                    arst_n,
	input  pctdec_pkg::entry_t     head,
	input  pctdec_pkg::q_stat_t    stat,
	output logic                   pop,
	input  wire                    out_stall,
	output logic                   out_valid,
	output pctdec_pkg::out_req_t   out_req
);

	logic                 out_valid_q;
	pctdec_pkg::out_req_t out_q;
	logic [1:0]           idx_q;
	logic                 load;
	logic                 is_end;
	logic [7:0]           cur;

	assign load      = !out_valid_q || !out_stall;
	assign is_end    = (idx_q == (head.n - 2'd1));
	assign pop       = load && !stat.empty && is_end;
	assign out_valid = out_valid_q;
	assign out_req   = out_q;

	always_comb begin
		case (idx_q)
			2'd0:    cur = head.bytes[0];
			2'd1:    cur = head.bytes[1];
			default: cur = head.bytes[2];
		endcase
	end

	always_ff @(posedge clk) begin
		if (load && !stat.empty) begin
			out_q.out_byte    <= cur;
			out_q.run_last    <= is_end;
			out_q.string_done <= is_end && head.done;
			out_q.overflow    <= head.ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= 2'd0;
		end else if (load) begin
			out_valid_q <= !stat.empty;
			if (!stat.empty) begin
				idx_q <= is_end ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	a_idx_in_entry: assert property (@(posedge clk) disable iff (!arst_n)
		!stat.empty |-> (idx_q < head.n))
		else $error("byte index past entry length");
	a_idle_idx: assert property (@(posedge clk) disable iff (!arst_n)
		stat.empty |-> (idx_q == 2'd0))
		else $error("byte index left nonzero with queue empty");
	a_ovf_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.overflow) |-> (out_q.run_last && out_q.string_done))
		else $error("overflow marker not a single closing result");

endmodule
`default_nettype wire

// ----- hw/rtl/percent_decoder.sv -----
// Top level of the URI percent decoder.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------
//  in      | in_valid / in_stall  | in_req  (in_byte, is_last)
//  out     | out_valid / out_stall| out_req (out_byte, run_last,
//          |                      |          string_done, overflow)
//  cfg     | cfg_valid / cfg_ready| cfg_data (output_limit)
//
// Unless stalled, one input byte is parsed per cycle into 0 to 3 bytes, sent one per cycle.
// A four-entry queue sits between parser and serializer; in_stall is raised only when full.
// Unstalled rate is one byte per cycle in and out, set by the single output register.
// Reset clears parser state, queue and output valid; output_limit returns to 4096.
// out_stall holds the output register; the queue absorbs bursts until it fills.
`default_nettype none
module percent_decoder #(
	parameter int COUNT_WIDTH = 16
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_stall,
	input  pctdec_pkg::in_req_t    in_req,
	output logic                   out_valid,
	input  wire                    out_stall,
	output pctdec_pkg::out_req_t   out_req,
	input  wire                    cfg_valid,
	output logic                   cfg_ready,
	input  wire [15:0]             cfg_data
);

	logic [15:0]          limit_q;
	logic                 accept;
	logic                 push;
	logic                 pop;
	pctdec_pkg::entry_t   wr_entry;
	pctdec_pkg::entry_t   rd_entry;
	pctdec_pkg::q_stat_t  stat;

	assign cfg_ready = 1'b1;
	assign in_stall  = stat.full;
	assign accept    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= 16'd4096;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_data;
		end
	end

	pctdec_front #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.accept(accept),
		.req   (in_req),
		.limit (limit_q),
		.push  (push),
		.entry (wr_entry)
	);

	pctdec_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_entry(wr_entry),
		.pop     (pop),
		.rd_entry(rd_entry),
		.stat    (stat)
	);

	pctdec_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (rd_entry),
		.stat     (stat),
		.pop      (pop),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.out_req  (out_req)
	);

endmodule
`default_nettype wire
